// ===== rtl/mid_side_soft_knee_compressor_defines.svh =====
// Assertion macros for the mid/side soft-knee compressor.
// Included by the top level; no other dependencies.
`ifndef MID_SIDE_SOFT_KNEE_COMPRESSOR_DEFINES_SVH
`define MID_SIDE_SOFT_KNEE_COMPRESSOR_DEFINES_SVH
`ifndef SYNTH
`define MSC_ASSERT_IMPLY(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define MSC_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define MSC_ASSERT_IMPLY(lbl, clk, rst, pre, post)
`define MSC_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

// ===== rtl/msc_pkg.sv =====
// Shared types, constants and constant tables of the compressor.
// No dependencies.
package msc_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int ENV_W = 24;
  localparam int ENV_SH = 23 - SAMPLE_WIDTH;

  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_SLOPE = 3'd1;
  localparam logic [2:0] REG_KNEE_WIDTH = 3'd2;
  localparam logic [2:0] REG_KNEE_SCALE = 3'd3;
  localparam logic [2:0] REG_ATTACK = 3'd4;
  localparam logic [2:0] REG_RELEASE = 3'd5;

  localparam logic [31:0] LOG_K = 32'd394566;
  localparam logic [31:0] EXP_K = 32'd2786635;
  localparam logic signed [15:0] GAIN_MIN = -16'sd30720;
  localparam logic signed [15:0] LEVEL_MIN = -16'sd32768;

  typedef struct packed {
    logic signed [15:0] threshold_db;
    logic [15:0] comp_slope;
    logic [12:0] knee_width_db;
    logic [15:0] knee_scale;
    logic [15:0] attack_coeff;
    logic [15:0] release_coeff;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = 64'd0;
    b = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (b > v) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 64'd0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  function automatic logic [29:0] exp_c(input int idx);
    logic [63:0] c;
    c = isqrt64(64'd1 << 59);
    for (int k = 0; k < 16; k++) begin
      if (k < idx) c = isqrt64(c << 30);
    end
    return c[29:0];
  endfunction

  localparam logic [29:0] EXP_C [16] = '{
    exp_c(0), exp_c(1), exp_c(2), exp_c(3), exp_c(4), exp_c(5), exp_c(6), exp_c(7),
    exp_c(8), exp_c(9), exp_c(10), exp_c(11), exp_c(12), exp_c(13), exp_c(14), exp_c(15)
  };

endpackage

// ===== rtl/msc_cfg.sv =====
// Configuration register file of the compressor.
// Depends on msc_pkg.
module msc_cfg (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data,
  output msc_pkg::cfg_t cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_db <= -16'sd5120;
      cfg.comp_slope <= 16'd32768;
      cfg.knee_width_db <= 13'd0;
      cfg.knee_scale <= 16'd0;
      cfg.attack_coeff <= 16'd64881;
      cfg.release_coeff <= 16'd65472;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        msc_pkg::REG_THRESHOLD: cfg.threshold_db <= $signed(cfg_data);
        msc_pkg::REG_SLOPE: cfg.comp_slope <= cfg_data;
        msc_pkg::REG_KNEE_WIDTH: cfg.knee_width_db <= cfg_data[12:0];
        msc_pkg::REG_KNEE_SCALE: cfg.knee_scale <= cfg_data;
        msc_pkg::REG_ATTACK: cfg.attack_coeff <= cfg_data;
        msc_pkg::REG_RELEASE: cfg.release_coeff <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/msc_core.sv =====
// Sequenced datapath: envelope, bit-serial log2, knee, bit-serial exp2, scaling.
// Depends on msc_pkg; shares one 32x32 multiplier across all steps.
module msc_core (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic ack,
  input  logic signed [msc_pkg::SAMPLE_WIDTH-1:0] left_in,
  input  logic signed [msc_pkg::SAMPLE_WIDTH-1:0] right_in,
  input  msc_pkg::cfg_t cfg,
  output msc_pkg::core_stat_t stat,
  output logic signed [msc_pkg::SAMPLE_WIDTH-1:0] left_res,
  output logic signed [msc_pkg::SAMPLE_WIDTH-1:0] right_res,
  output logic signed [15:0] gain_res
);

  localparam int SW = msc_pkg::SAMPLE_WIDTH;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_ENV0  = 14'b00000000000010,
    S_ENV1  = 14'b00000000000100,
    S_LOGN  = 14'b00000000001000,
    S_LOGI  = 14'b00000000010000,
    S_LVL   = 14'b00000000100000,
    S_GAIN0 = 14'b00000001000000,
    S_GAIN1 = 14'b00000010000000,
    S_EXPE  = 14'b00000100000000,
    S_EXPI  = 14'b00001000000000,
    S_EXPS  = 14'b00010000000000,
    S_APM   = 14'b00100000000000,
    S_APS   = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t state;
  logic signed [SW:0] m2;
  logic signed [SW:0] s2;
  logic [23:0] env;
  logic [23:0] pk_r;
  logic [15:0] coef_r;
  logic [63:0] acc;
  logic [31:0] x;
  logic [20:0] l2;
  logic [3:0] cnt;
  logic signed [15:0] lvl;
  logic signed [15:0] g;
  logic [30:0] y;
  logic [15:0] fbits;
  logic [4:0] nsh;
  logic signed [SW+1:0] mg;
  logic signed [SW+1:0] sg;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [SW:0] am;
  logic [SW:0] as;
  logic [SW:0] pk;
  logic [47:0] pk_ext;
  logic [47:0] pk_wide;
  logic [23:0] pk_sc;
  logic [4:0] p;
  logic [31:0] sq;
  logic [20:0] rel;
  logic [63:0] psum;
  logic signed [17:0] d;
  logic signed [18:0] d2;
  logic signed [18:0] wk;
  logic signed [18:0] x2;
  logic [15:0] ag;
  logic [SW:0] mag;
  logic signed [SW+2:0] lsum;
  logic signed [SW+2:0] rsum;
  logic signed [SW+1:0] lhalf;
  logic signed [SW+1:0] rhalf;

  function automatic logic signed [15:0] gain_clamp(input logic [47:0] v);
    logic signed [15:0] r;
    if (v > 48'd30720) r = msc_pkg::GAIN_MIN;
    else r = 16'(17'sd0 - $signed({1'b0, v[15:0]}));
    return r;
  endfunction

  function automatic logic signed [SW-1:0] sat(input logic signed [SW+1:0] v);
    logic signed [SW-1:0] r;
    if (v > $signed({3'b000, {(SW-1){1'b1}}})) r = {1'b0, {(SW-1){1'b1}}};
    else if (v < $signed({3'b111, {(SW-1){1'b0}}})) r = {1'b1, {(SW-1){1'b0}}};
    else r = v[SW-1:0];
    return r;
  endfunction

  assign am = m2[SW] ? (~m2 + 1'b1) : m2;
  assign as = s2[SW] ? (~s2 + 1'b1) : s2;
  assign pk = (am > as) ? am : as;
  assign pk_ext = {{(47-SW){1'b0}}, pk};
  assign pk_wide = (msc_pkg::ENV_SH >= 0) ? (pk_ext << msc_pkg::ENV_SH)
                                          : (pk_ext >> (-msc_pkg::ENV_SH));
  assign pk_sc = pk_wide[23:0];

  always_comb begin
    p = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (env[i]) p = 5'(i);
    end
  end

  assign d = {{2{lvl[15]}}, lvl} - {{2{cfg.threshold_db[15]}}, cfg.threshold_db};
  assign d2 = {d, 1'b0};
  assign wk = {6'b0, cfg.knee_width_db};
  assign x2 = d2 + wk;
  assign ag = 16'(17'sd0 - 17'(g));
  assign rel = (l2 > 21'(23 * 65536)) ? 21'd0 : 21'(23 * 65536) - l2;
  assign sq = prod[61:30];

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state)
      S_ENV0: begin
        mul_a = {16'b0, (pk_sc > env) ? cfg.attack_coeff : cfg.release_coeff};
        mul_b = {8'b0, env};
      end
      S_ENV1: begin
        mul_a = {15'b0, 17'(17'h10000 - {1'b0, coef_r})};
        mul_b = {8'b0, pk_r};
      end
      S_LOGI: begin
        mul_a = x;
        mul_b = x;
      end
      S_LVL: begin
        mul_a = {11'b0, rel};
        mul_b = msc_pkg::LOG_K;
      end
      S_GAIN0: begin
        if (d2 > wk) begin
          mul_a = {14'b0, d};
          mul_b = {16'b0, cfg.comp_slope};
        end else begin
          mul_a = {18'b0, x2[13:0]};
          mul_b = {18'b0, x2[13:0]};
        end
      end
      S_GAIN1: begin
        mul_a = {4'b0, acc[27:0]};
        mul_b = {16'b0, cfg.knee_scale};
      end
      S_EXPE: begin
        mul_a = {16'b0, ag};
        mul_b = msc_pkg::EXP_K;
      end
      S_EXPI: begin
        mul_a = {1'b0, y};
        mul_b = {2'b0, msc_pkg::EXP_C[cnt]};
      end
      S_APM: begin
        mul_a = {{(31-SW){1'b0}}, am};
        mul_b = {1'b0, y};
      end
      S_APS: begin
        mul_a = {{(31-SW){1'b0}}, as};
        mul_b = {1'b0, y};
      end
      default: begin
      end
    endcase
  end

  assign prod = {32'b0, mul_a} * {32'b0, mul_b};

  always_comb begin
    unique case (state)
      S_ENV1: psum = acc + prod + 64'd32768;
      S_LVL: psum = prod + 64'd8388608;
      S_GAIN0: psum = prod + 64'd32768;
      S_GAIN1: psum = prod + 64'd33554432;
      S_EXPE: psum = prod + 64'd32768;
      default: psum = prod + 64'd536870912;
    endcase
  end

  assign mag = psum[SW+30:30];
  assign lsum = {mg[SW+1], mg} + {sg[SW+1], sg};
  assign rsum = {mg[SW+1], mg} - {sg[SW+1], sg};
  assign lhalf = lsum[SW+2:1];
  assign rhalf = rsum[SW+2:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      env <= 24'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            m2 <= {left_in[SW-1], left_in} + {right_in[SW-1], right_in};
            s2 <= {left_in[SW-1], left_in} - {right_in[SW-1], right_in};
            state <= S_ENV0;
          end
        end
        S_ENV0: begin
          acc <= prod;
          pk_r <= pk_sc;
          coef_r <= (pk_sc > env) ? cfg.attack_coeff : cfg.release_coeff;
          state <= S_ENV1;
        end
        S_ENV1: begin
          env <= psum[39:16];
          state <= S_LOGN;
        end
        S_LOGN: begin
          cnt <= 4'd0;
          if (env == 24'd0) begin
            lvl <= msc_pkg::LEVEL_MIN;
            state <= S_GAIN0;
          end else begin
            x <= {8'b0, env} << (5'd30 - p);
            l2 <= {p, 16'b0};
            state <= S_LOGI;
          end
        end
        S_LOGI: begin
          if (sq[31]) begin
            x <= sq >> 1;
            l2 <= l2 | (21'd1 << (4'd15 - cnt));
          end else begin
            x <= sq;
          end
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) state <= S_LVL;
        end
        S_LVL: begin
          if (psum[40:24] > 17'd32768) lvl <= msc_pkg::LEVEL_MIN;
          else lvl <= 16'(18'sd0 - $signed({1'b0, psum[40:24]}));
          state <= S_GAIN0;
        end
        S_GAIN0: begin
          if (cfg.knee_width_db == 13'd0) begin
            if (d <= 18'sd0) g <= 16'sd0;
            else g <= gain_clamp(psum[63:16]);
            state <= S_EXPE;
          end else if (d2 < -wk) begin
            g <= 16'sd0;
            state <= S_EXPE;
          end else if (d2 > wk) begin
            g <= gain_clamp(psum[63:16]);
            state <= S_EXPE;
          end else begin
            acc <= prod;
            state <= S_GAIN1;
          end
        end
        S_GAIN1: begin
          g <= gain_clamp({10'b0, psum[63:26]});
          state <= S_EXPE;
        end
        S_EXPE: begin
          nsh <= psum[36:32];
          fbits <= psum[31:16];
          y <= 31'h4000_0000;
          cnt <= 4'd0;
          state <= S_EXPI;
        end
        S_EXPI: begin
          if (fbits[4'd15 - cnt]) y <= prod[60:30];
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) state <= S_EXPS;
        end
        S_EXPS: begin
          y <= y >> nsh;
          state <= S_APM;
        end
        S_APM: begin
          mg <= m2[SW] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
          state <= S_APS;
        end
        S_APS: begin
          sg <= s2[SW] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
          state <= S_DONE;
        end
        S_DONE: begin
          if (ack) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_DONE);
  assign left_res = sat(lhalf);
  assign right_res = sat(rhalf);
  assign gain_res = g;

endmodule

// ===== rtl/mid_side_soft_knee_compressor.sv =====
// Each accepted word runs through the shared multiplier sequence of msc_core, with its two
// 16-step loops (log2 squarings and exp2 products); the soft-knee curve adds a knee-scale
// multiply and a zero envelope skips the log2 loop. A new word is taken only once the core
// is idle again, so a stalled result holds the next word off.
// Reset clears the sequencer, the envelope and the output valid and loads register defaults.
// Depends on msc_pkg, msc_cfg, msc_core and the assertion macro header.
`include "mid_side_soft_knee_compressor_defines.svh"
module mid_side_soft_knee_compressor (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [msc_pkg::SAMPLE_WIDTH-1:0] left_in,
  input  logic signed [msc_pkg::SAMPLE_WIDTH-1:0] right_in,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [msc_pkg::SAMPLE_WIDTH-1:0] left_out,
  output logic signed [msc_pkg::SAMPLE_WIDTH-1:0] right_out,
  output logic signed [15:0] gain_reduction_db,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);

  msc_pkg::cfg_t cfg;
  msc_pkg::core_stat_t stat;
  logic take;
  logic gain_ok;
  logic signed [msc_pkg::SAMPLE_WIDTH-1:0] left_res;
  logic signed [msc_pkg::SAMPLE_WIDTH-1:0] right_res;
  logic signed [15:0] gain_res;

  msc_cfg u_cfg (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
  );

  assign take = !out_valid || !out_stall;
  assign in_stall = !stat.idle;

  msc_core u_core (
    .clk(clk), .rst(rst), .start(in_valid && !in_stall), .ack(take),
    .left_in(left_in), .right_in(right_in), .cfg(cfg), .stat(stat),
    .left_res(left_res), .right_res(right_res), .gain_res(gain_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.done && take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done && take) begin
      left_out <= left_res;
      right_out <= right_res;
      gain_reduction_db <= gain_res;
    end
  end

  assign gain_ok = (gain_reduction_db <= 16'sd0) && (gain_reduction_db >= msc_pkg::GAIN_MIN);

  `MSC_ASSERT_NEXT(a_done_returns_idle, clk, rst, stat.done && take, stat.idle)
  `MSC_ASSERT_NEXT(a_accept_blocks_next, clk, rst, in_valid && !in_stall, in_stall)
  `MSC_ASSERT_IMPLY(a_gain_range, clk, rst, out_valid, gain_ok)

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the mid/side soft-knee compressor.
// Predicts each output word from its own fixed-point envelope, log2, knee and exp2 model.
// Depends on msc_pkg and the mid_side_soft_knee_compressor RTL.
`timescale 1ns / 1ps
module tb_top;

  localparam int SW = msc_pkg::SAMPLE_WIDTH;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
  } pair_t;

  typedef struct {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
    logic signed [15:0] gain;
  } comp_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SW-1:0] left_in = '0;
  logic signed [SW-1:0] right_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SW-1:0] left_out;
  logic signed [SW-1:0] right_out;
  logic signed [15:0] gain_reduction_db;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  pair_t pending_pairs[$];
  comp_word_t expected_words[$];
  msc_pkg::cfg_t model_cfg;
  logic [23:0] model_env;
  int mismatches = 0;
  int cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_phase = 0;
  int stall_mode = 0;

  mid_side_soft_knee_compressor u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned sqrt_floor(input longint unsigned v_in);
    longint unsigned v, r, b;
    v = v_in;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint level_of_env(input logic [23:0] env);
    int p;
    longint unsigned x, l2, rel;
    longint lvl;
    if (env == 0) return -32768;
    p = 0;
    for (int i = 0; i < 24; i++) if (env[i]) p = i;
    x = longint'(env) << (30 - p);
    l2 = longint'(p) << 16;
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        l2 = l2 | (64'd1 << (15 - i));
      end
    end
    rel = (l2 > (64'd23 << 16)) ? 0 : (64'd23 << 16) - l2;
    lvl = -longint'((rel * 394566 + (64'd1 << 23)) >> 24);
    return lvl < -32768 ? -32768 : lvl;
  endfunction

  function automatic longint knee_gain(input longint lvl);
    longint d, d2, w, g;
    longint unsigned x2;
    logic linear;
    d = lvl - longint'(model_cfg.threshold_db);
    w = longint'(model_cfg.knee_width_db);
    d2 = 2 * d;
    if (w == 0) begin
      if (d <= 0) return 0;
      linear = 1'b1;
    end else begin
      if (d2 < -w) return 0;
      linear = d2 > w;
    end
    if (linear) begin
      g = -longint'((longint'(d) * longint'(model_cfg.comp_slope) + 32768) >> 16);
    end else begin
      x2 = d2 + w;
      g = -longint'((x2 * x2 * longint'(model_cfg.knee_scale) + (64'd1 << 25)) >> 26);
    end
    return g < -30720 ? -30720 : g;
  endfunction

  function automatic longint unsigned gain_factor(input longint g);
    longint unsigned e, n, f, y, c;
    e = (longint'(-g) * 2786635 + 32768) >> 16;
    n = e >> 16;
    f = e & 16'hFFFF;
    y = 64'd1 << 30;
    c = sqrt_floor(64'd1 << 59);
    for (int i = 0; i < 16; i++) begin
      if (f[15-i]) y = (y * c) >> 30;
      c = sqrt_floor(c << 30);
    end
    return n >= 31 ? 0 : y >> n;
  endfunction

  function automatic longint scale_signed(input longint v, input longint unsigned y);
    longint unsigned mag;
    longint p;
    mag = v < 0 ? -v : v;
    p = (mag * y + (64'd1 << 29)) >> 30;
    return v < 0 ? -p : p;
  endfunction

  function automatic logic signed [SW-1:0] halve_sat(input longint v);
    longint h;
    h = v >= 0 ? v / 2 : -((-v + 1) / 2);
    if (h > 32767) h = 32767;
    if (h < -32768) h = -32768;
    return h[SW-1:0];
  endfunction

  function automatic comp_word_t compress_pair(input pair_t pr);
    longint m2, s2, am, as_, pk, c, lvl, g, mg, sg;
    longint unsigned y;
    comp_word_t w;
    m2 = longint'(pr.left) + longint'(pr.right);
    s2 = longint'(pr.left) - longint'(pr.right);
    am = m2 < 0 ? -m2 : m2;
    as_ = s2 < 0 ? -s2 : s2;
    pk = (am > as_ ? am : as_) << msc_pkg::ENV_SH;
    c = pk > longint'(model_env) ? longint'(model_cfg.attack_coeff)
                                 : longint'(model_cfg.release_coeff);
    model_env = 24'((c * longint'(model_env) + (65536 - c) * pk + 32768) >> 16);
    lvl = level_of_env(model_env);
    g = knee_gain(lvl);
    y = gain_factor(g);
    mg = scale_signed(m2, y);
    sg = scale_signed(s2, y);
    w.left = halve_sat(mg + sg);
    w.right = halve_sat(mg - sg);
    w.gain = g[15:0];
    return w;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_words.push_back(compress_pair(pending_pairs.pop_front()));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() > 0 && !(in_valid && !in_stall &&
                     pending_pairs.size() == 0)) begin
          in_valid <= 1'b1;
          left_in <= pending_pairs[0].left;
          right_in <= pending_pairs[0].right;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 60);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern changes among four modes, chosen at random.
  always @(posedge clk) begin
    if (!rst) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 256 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= (stall_phase % 7) < 4;
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  always @(posedge clk) begin
    comp_word_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected output word at cycle %0d: L=%0d R=%0d G=%0d",
                   cycles, left_out, right_out, gain_reduction_db);
        end
      end else begin
        exp_w = expected_words.pop_front();
        if (exp_w.left !== left_out || exp_w.right !== right_out ||
            exp_w.gain !== gain_reduction_db) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected L=%0d R=%0d G=%0d, got L=%0d R=%0d G=%0d",
                     exp_w.left, exp_w.right, exp_w.gain,
                     left_out, right_out, gain_reduction_db);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      msc_pkg::REG_THRESHOLD: model_cfg.threshold_db = val;
      msc_pkg::REG_SLOPE: model_cfg.comp_slope = val;
      msc_pkg::REG_KNEE_WIDTH: model_cfg.knee_width_db = val[12:0];
      msc_pkg::REG_KNEE_SCALE: model_cfg.knee_scale = val;
      msc_pkg::REG_ATTACK: model_cfg.attack_coeff = val;
      msc_pkg::REG_RELEASE: model_cfg.release_coeff = val;
      default: ;
    endcase
  endtask

  task automatic drain_all();
    while (pending_pairs.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic add_pair(input logic [15:0] l, input logic [15:0] r);
    pair_t p;
    p.left = l;
    p.right = r;
    pending_pairs.push_back(p);
  endtask

  task automatic add_random(input int count);
    logic [15:0] l, r, amp;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 4))
        0: amp = 16'h7FFF;
        1: amp = 16'h0FFF;
        2: amp = 16'h00FF;
        default: amp = 16'hFFFF;
      endcase
      l = 16'($urandom()) & amp;
      r = 16'($urandom()) & amp;
      if (amp != 16'hFFFF && $urandom_range(0, 1)) l = -l;
      if ($urandom_range(0, 7) == 0) r = l;
      else if ($urandom_range(0, 7) == 0) r = -l;
      add_pair(l, r);
    end
  endtask

  task automatic random_config();
    logic [12:0] kw;
    write_reg(msc_pkg::REG_THRESHOLD, 16'(-$urandom_range(0, 30720)));
    write_reg(msc_pkg::REG_SLOPE, 16'($urandom_range(0, 65535)));
    kw = $urandom_range(0, 3) == 0 ? 13'd0 : 13'($urandom_range(0, 6144));
    write_reg(msc_pkg::REG_KNEE_WIDTH, {3'b000, kw});
    write_reg(msc_pkg::REG_KNEE_SCALE, 16'($urandom_range(0, 65535)));
    write_reg(msc_pkg::REG_ATTACK, 16'($urandom_range(0, 65535)));
    write_reg(msc_pkg::REG_RELEASE, 16'($urandom_range(0, 65535)));
  endtask

  initial begin
    model_cfg.threshold_db = -16'sd5120;
    model_cfg.comp_slope = 16'd32768;
    model_cfg.knee_width_db = '0;
    model_cfg.knee_scale = '0;
    model_cfg.attack_coeff = 16'd64881;
    model_cfg.release_coeff = 16'd65472;
    model_env = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Default registers: silence, full-scale extremes, pure mid and pure side.
    add_pair(16'h0000, 16'h0000);
    add_pair(16'h7FFF, 16'h7FFF);
    add_pair(16'h8000, 16'h8000);
    add_pair(16'h7FFF, 16'h8000);
    add_pair(16'h8000, 16'h7FFF);
    add_pair(16'h0001, 16'hFFFF);
    add_pair(16'hFFFF, 16'hFFFF);
    add_pair(16'h4000, 16'h0000);
    drain_all();

    // Soft knee with a mismatched scale, fast attack, hard limits on registers.
    write_reg(msc_pkg::REG_THRESHOLD, 16'h0000);
    write_reg(msc_pkg::REG_SLOPE, 16'hFFFF);
    write_reg(msc_pkg::REG_KNEE_WIDTH, 16'd6144);
    write_reg(msc_pkg::REG_KNEE_SCALE, 16'hFFFF);
    write_reg(msc_pkg::REG_ATTACK, 16'h0000);
    write_reg(msc_pkg::REG_RELEASE, 16'hFFFF);
    add_pair(16'h7FFF, 16'h7FFF);
    add_pair(16'h8000, 16'h7FFF);
    add_pair(16'h0000, 16'h0000);
    add_pair(16'h1234, 16'hEDCB);
    drain_all();

    // A very low threshold and the steepest slope drive the gain to its clamp.
    write_reg(msc_pkg::REG_THRESHOLD, 16'h8800);
    write_reg(msc_pkg::REG_KNEE_WIDTH, 16'd0);
    write_reg(msc_pkg::REG_RELEASE, 16'h0000);
    add_pair(16'h7FFF, 16'h7FFF);
    add_pair(16'h0001, 16'h0000);
    add_pair(16'h8000, 16'h8000);
    add_pair(16'h0000, 16'h0000);
    drain_all();
    // Threshold above 0 dB and out-of-range register patterns.
    write_reg(msc_pkg::REG_THRESHOLD, 16'h7FFF);
    write_reg(msc_pkg::REG_KNEE_WIDTH, 16'h1FFF);
    add_pair(16'h7FFF, 16'h8000);
    add_pair(16'h5555, 16'hAAAA);
    drain_all();
    write_reg(REG_UNUSED, 16'hFFFF);

    for (int ph = 0; ph < 7; ph++) begin
      random_config();
      add_random(250);
      drain_all();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== mid_side_soft_knee_compressor.f =====
+incdir+rtl
rtl/msc_pkg.sv
rtl/msc_cfg.sv
rtl/msc_core.sv
rtl/mid_side_soft_knee_compressor.sv
verif/tb_top.sv
